FILE: rtl/dgc_pkg.sv
// dgc_pkg: shared types, constants and the microcode table of diophantine_gcd_check
// used by dgc_sequencer, dgc_datapath and the top level; no dependencies
package dgc_pkg;

  localparam int unsigned WordWidthDefault = 32;
  localparam int unsigned FieldWidth       = 32;
  localparam int unsigned PcWidth          = 5;

  typedef logic [PcWidth-1:0] pc_t;

  // program entry points
  localparam pc_t PcIdle    = pc_t'(0);
  localparam pc_t PcEuclid  = pc_t'(3);
  localparam pc_t PcDivLoop = pc_t'(5);
  localparam pc_t PcKeepB   = pc_t'(7);
  localparam pc_t PcFinish  = pc_t'(8);
  localparam pc_t PcChkLoop = pc_t'(12);
  localparam pc_t PcEmitOk  = pc_t'(14);
  localparam pc_t PcFail    = pc_t'(16);
  localparam pc_t ProgLen   = pc_t'(18);

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_TAKE      = 4'd1,
    OP_DIV_INIT  = 4'd2,
    OP_DIV_STEP  = 4'd3,
    OP_ROTATE    = 4'd4,
    OP_KEEP_B    = 4'd5,
    OP_LOAD_RHS  = 4'd6,
    OP_EMIT_OK   = 4'd7,
    OP_EMIT_FAIL = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    COND_NEXT      = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_WAIT_IN   = 4'd2,
    COND_COEF_ZERO = 4'd3,
    COND_NOT_SEEN  = 4'd4,
    COND_A_ZERO    = 4'd5,
    COND_DIV_MORE  = 4'd6,
    COND_NOT_LAST  = 4'd7,
    COND_RHS_BAD   = 4'd8,
    COND_REM_NZ    = 4'd9,
    COND_WAIT_OUT  = 4'd10
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic wait_in;
    logic coef_zero;
    logic not_seen;
    logic a_zero;
    logic div_more;
    logic not_last;
    logic rhs_bad;
    logic rem_nz;
    logic wait_out;
  } flags_t;

  function automatic ctrl_t ucode_word(op_e op, cond_e cond, pc_t target);
    ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode_fetch(pc_t pc);
    ctrl_t w;
    unique case (pc)
      pc_t'(0):  w = ucode_word(OP_TAKE,      COND_WAIT_IN,   PcIdle);
      pc_t'(1):  w = ucode_word(OP_NONE,      COND_COEF_ZERO, PcFinish);
      pc_t'(2):  w = ucode_word(OP_NONE,      COND_NOT_SEEN,  PcKeepB);
      pc_t'(3):  w = ucode_word(OP_NONE,      COND_A_ZERO,    PcKeepB);
      pc_t'(4):  w = ucode_word(OP_DIV_INIT,  COND_NEXT,      PcIdle);
      pc_t'(5):  w = ucode_word(OP_DIV_STEP,  COND_DIV_MORE,  PcDivLoop);
      pc_t'(6):  w = ucode_word(OP_ROTATE,    COND_ALWAYS,    PcEuclid);
      pc_t'(7):  w = ucode_word(OP_KEEP_B,    COND_NEXT,      PcIdle);
      pc_t'(8):  w = ucode_word(OP_NONE,      COND_NOT_LAST,  PcIdle);
      pc_t'(9):  w = ucode_word(OP_NONE,      COND_RHS_BAD,   PcFail);
      pc_t'(10): w = ucode_word(OP_LOAD_RHS,  COND_NEXT,      PcIdle);
      pc_t'(11): w = ucode_word(OP_DIV_INIT,  COND_NEXT,      PcIdle);
      pc_t'(12): w = ucode_word(OP_DIV_STEP,  COND_DIV_MORE,  PcChkLoop);
      pc_t'(13): w = ucode_word(OP_NONE,      COND_REM_NZ,    PcFail);
      pc_t'(14): w = ucode_word(OP_EMIT_OK,   COND_WAIT_OUT,  PcEmitOk);
      pc_t'(15): w = ucode_word(OP_NONE,      COND_ALWAYS,    PcIdle);
      pc_t'(16): w = ucode_word(OP_EMIT_FAIL, COND_WAIT_OUT,  PcFail);
      pc_t'(17): w = ucode_word(OP_NONE,      COND_ALWAYS,    PcIdle);
      default:   w = ucode_word(OP_NONE,      COND_ALWAYS,    PcIdle);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dgc_sequencer.sv
// dgc_sequencer: step counter, control store fetch and conditional jumps
// depends on dgc_pkg
module dgc_sequencer import dgc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output pc_t    pc_o
);

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  logic  jump;

  assign ctrl = ucode_fetch(pc_q);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:      jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_WAIT_IN:   jump = flags_i.wait_in;
      COND_COEF_ZERO: jump = flags_i.coef_zero;
      COND_NOT_SEEN:  jump = flags_i.not_seen;
      COND_A_ZERO:    jump = flags_i.a_zero;
      COND_DIV_MORE:  jump = flags_i.div_more;
      COND_NOT_LAST:  jump = flags_i.not_last;
      COND_RHS_BAD:   jump = flags_i.rhs_bad;
      COND_REM_NZ:    jump = flags_i.rem_nz;
      COND_WAIT_OUT:  jump = flags_i.wait_out;
      default:        jump = 1'b1;
    endcase
    pc_d = jump ? ctrl.target : pc_t'(pc_q + pc_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign pc_o   = pc_q;

endmodule

FILE: rtl/dgc_datapath.sv
// dgc_datapath: operand registers, bit-serial remainder unit and result register
// depends on dgc_pkg; driven by the control word of dgc_sequencer
module dgc_datapath import dgc_pkg::*; #(
  parameter int unsigned WordWidth = WordWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output flags_t                flags_o,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FieldWidth-1:0] in_coef_i,
  input  logic [FieldWidth-1:0] in_rhs_i,
  input  logic                  in_known_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_solvable_o,
  output logic [FieldWidth-1:0] out_gcd_o
);

  localparam int unsigned CntWidth = $clog2(WordWidth + 1);

  logic signed [WordWidth-1:0] a_q, a_d, b_q, b_d, rhs_q, rhs_d;
  logic                        known_q, known_d, last_q, last_d, seen_q, seen_d;
  logic        [WordWidth-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic                        neg_q, neg_d;
  logic        [CntWidth-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d, out_solv_q, out_solv_d;
  logic        [FieldWidth-1:0] out_gcd_q, out_gcd_d;

  logic signed [WordWidth-1:0] coef_w, rhs_w;
  logic        [WordWidth-1:0] partial, b_mag, a_mag;
  logic                        out_free, in_fire, a_zero;

  // fields sign-extended or wrapped to the word width
  assign coef_w = WordWidth'(signed'(in_coef_i));
  assign rhs_w  = WordWidth'(signed'(in_rhs_i));

  assign in_fire  = in_valid_i && (ctrl_i.op == OP_TAKE);
  assign out_free = !out_valid_q || out_ready_i;
  assign a_zero   = (a_q == '0);
  assign b_mag    = b_q[WordWidth-1] ? WordWidth'(-b_q) : WordWidth'(b_q);
  assign a_mag    = a_q[WordWidth-1] ? WordWidth'(-a_q) : WordWidth'(a_q);
  assign partial  = {rem_q[WordWidth-2:0], quo_q[WordWidth-1]};

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    rhs_d       = rhs_q;
    known_d     = known_q;
    last_d      = last_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dsr_d       = dsr_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_solv_d  = out_solv_q;
    out_gcd_d   = out_gcd_q;
    unique case (ctrl_i.op)
      OP_TAKE: begin
        if (in_fire) begin
          b_d     = coef_w;
          rhs_d   = rhs_w;
          known_d = in_known_i;
          last_d  = in_last_i;
        end
      end
      OP_DIV_INIT: begin
        rem_d = '0;
        quo_d = b_mag;
        dsr_d = a_mag;
        neg_d = b_q[WordWidth-1];
        cnt_d = CntWidth'(WordWidth);
      end
      OP_DIV_STEP: begin
        rem_d = (partial >= dsr_q) ? WordWidth'(partial - dsr_q) : partial;
        quo_d = {quo_q[WordWidth-2:0], 1'b0};
        cnt_d = CntWidth'(cnt_q - CntWidth'(1));
      end
      OP_ROTATE: begin
        b_d = a_q;
        a_d = neg_q ? WordWidth'(-rem_q) : rem_q;
      end
      OP_KEEP_B: begin
        a_d    = b_q;
        seen_d = 1'b1;
      end
      OP_LOAD_RHS: begin
        b_d = rhs_q;
      end
      OP_EMIT_OK, OP_EMIT_FAIL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_solv_d  = (ctrl_i.op == OP_EMIT_OK);
          out_gcd_d   = (ctrl_i.op == OP_EMIT_OK) ? FieldWidth'(a_q) : '0;
          a_d         = '0;
          seen_d      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_q         <= a_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    rhs_q      <= rhs_d;
    known_q    <= known_d;
    last_q     <= last_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dsr_q      <= dsr_d;
    neg_q      <= neg_d;
    out_solv_q <= out_solv_d;
    out_gcd_q  <= out_gcd_d;
  end

  always_comb begin
    flags_o.wait_in   = !in_valid_i;
    flags_o.coef_zero = (b_q == '0);
    flags_o.not_seen  = !seen_q;
    flags_o.a_zero    = a_zero;
    flags_o.div_more  = (cnt_q != CntWidth'(1));
    flags_o.not_last  = !last_q;
    flags_o.rhs_bad   = !seen_q || !known_q || a_zero;
    flags_o.rem_nz    = (rem_q != '0);
    flags_o.wait_out  = !out_free;
  end

  assign in_ready_o     = (ctrl_i.op == OP_TAKE);
  assign out_valid_o    = out_valid_q;
  assign out_solvable_o = out_solv_q;
  assign out_gcd_o      = out_gcd_q;

endmodule

FILE: rtl/diophantine_gcd_check.sv
// diophantine_gcd_check: top level, solvability test of a1*x1+...+an*xn = c
// depends on dgc_pkg, dgc_sequencer and dgc_datapath
//
//   port group  dir  words                          handshake
//   s_axis      in   one coefficient, c on last     tvalid/tready, tlast ends equation
//   m_axis      out  solvable and gcd, once per eq  tvalid/tready
//
// each further nonzero coefficient folds into the running gcd by Euclid remainder steps
// the last item adds the divisibility check of c
// remainders come from a bit-serial restoring unit, one quotient bit per cycle
// s_axis_tready_o is high only in the fetch step; a full output word stalls only the emit step
// reset clears the step counter, running gcd, seen flag, division bit counter and output valid
module diophantine_gcd_check import dgc_pkg::*; #(
  parameter int unsigned WordWidth = WordWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // coefficient[31:0], rhs_value[63:32]
  input  logic        s_axis_tuser_i,   // rhs_known
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // solvable[0], gcd_value[32:1], zero[39:33]
);

  ctrl_t                 ctrl;
  flags_t                flags;
  pc_t                   pc;
  logic                  out_solv;
  logic [FieldWidth-1:0] out_gcd;

  dgc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .pc_o    (pc)
  );

  dgc_datapath #(
    .WordWidth (WordWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_coef_i      (s_axis_tdata_i[31:0]),
    .in_rhs_i       (s_axis_tdata_i[63:32]),
    .in_known_i     (s_axis_tuser_i),
    .in_last_i      (s_axis_tlast_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_solvable_o (out_solv),
    .out_gcd_o      (out_gcd)
  );

  assign m_axis_tdata_o = {7'b0, out_gcd, out_solv};

  // step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc < ProgLen)
    else $error("step counter left the program");

  // the remainder unit never runs against a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_DIV_STEP) |-> !flags.a_zero)
    else $error("division step with zero divisor");

  // no result can appear right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("result raised directly after input");

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for diophantine_gcd_check, stream words in, verdicts out
// depends on rtl/dgc_pkg.sv and rtl/diophantine_gcd_check.sv; holds its own gcd predictor
`timescale 1ns / 1ps

module tb;

  localparam logic [31:0] MinWord = 32'h8000_0000;
  localparam logic [31:0] MaxWord = 32'h7fff_ffff;
  localparam logic [31:0] NegOne  = 32'hffff_ffff;
  localparam int unsigned NumRows     = 24;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned HoldCycles  = 3000;

  typedef struct packed {
    logic        solvable;
    logic [31:0] gcd;
  } verdict_t;

  typedef struct packed {
    logic [31:0] coef;
    logic [31:0] rhs;
    logic        known;
    logic        last;
    logic        typed;
    logic        solv;
    logic [31:0] gcd;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [63:0] s_data;   // coefficient[31:0], rhs_value[63:32]
  logic        s_user;   // rhs_known
  logic        s_last;   // last
  logic        m_valid;
  logic        m_ready;
  logic [39:0] m_data;   // solvable[0], gcd_value[32:1], zero[39:33]

  verdict_t           expected_verdicts[$];
  logic signed [31:0] gcd_acc;
  logic               any_nonzero;
  logic               gaps_on;
  logic               hold_req;
  int unsigned        mismatches;
  int unsigned        n_words;
  int unsigned        n_eqs;
  int unsigned        n_solvable;

  // special rows: no coefficient, unknown c, remainder by minus one, extremes, long euclid
  row_t directed_rows [0:NumRows-1] = '{
    '{32'd0,          32'd0,          1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{32'd5,          32'd10,         1'b0, 1'b1, 1'b1, 1'b0, 32'd0},
    '{32'd6,          32'd12,         1'b1, 1'b1, 1'b1, 1'b1, 32'd6},
    '{32'd6,          32'd13,         1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{NegOne,         32'd7,          1'b1, 1'b1, 1'b1, 1'b1, NegOne},
    '{MinWord,        MinWord,        1'b1, 1'b1, 1'b1, 1'b1, MinWord},
    '{MinWord,        32'd1234,       1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{NegOne,         32'd3,          1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{MaxWord,        NegOne,         1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{MinWord,        MaxWord,        1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{32'd0,          32'd55,         1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd12,         32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd0,          32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd18,         32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd0,          32'd30,         1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{32'd1836311903, 32'haaaa_aaaa,  1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd1134903170, 32'd5,          1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{32'hffff_fffc,  32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd6,          32'hffff_fffe,  1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{32'd2,          MinWord,        1'b1, 1'b1, 1'b1, 1'b1, 32'd2},
    '{32'd0,          32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{32'd0,          32'd0,          1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{32'd3,          NegOne,         1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{MaxWord,        32'd0,          1'b1, 1'b1, 1'b1, 1'b1, MaxWord}
  };

  diophantine_gcd_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("simulation failed");
    $finish;
  end

  // truncated remainder, zero for a divisor of zero or minus one
  function automatic logic signed [31:0] trunc_rem32(input logic signed [31:0] num,
                                                     input logic signed [31:0] den);
    if (den == 0 || den == -1) return 0;
    return num % den;
  endfunction

  function automatic logic signed [31:0] euclid_gcd(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [31:0] t;
    while (a != 0) begin
      t = a;
      a = trunc_rem32(b, a);
      b = t;
    end
    return b;
  endfunction

  function automatic void fold_word(input logic signed [31:0] coef, input logic signed [31:0] rhs,
                                    input logic known, input logic last,
                                    output logic has_res, output verdict_t v);
    has_res = 1'b0;
    v = '0;
    if (coef != 0) begin
      gcd_acc = any_nonzero ? euclid_gcd(gcd_acc, coef) : coef;
      any_nonzero = 1'b1;
    end
    if (last) begin
      has_res = 1'b1;
      if (any_nonzero && known && gcd_acc != 0 && trunc_rem32(rhs, gcd_acc) == 0) begin
        v.solvable = 1'b1;
        v.gcd = gcd_acc;
      end
      gcd_acc = 0;
      any_nonzero = 1'b0;
    end
  endfunction

  task automatic send_word(input logic [31:0] coef, input logic [31:0] rhs, input logic known,
                           input logic last, input logic typed, input logic t_solv,
                           input logic [31:0] t_gcd);
    logic     has_res;
    verdict_t v;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {rhs, coef};
    s_user  = known;
    s_last  = last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    fold_word(coef, rhs, known, last, has_res, v);
    if (has_res) begin
      if (typed) begin
        v.solvable = t_solv;
        v.gcd = t_gcd;
      end
      expected_verdicts.push_back(v);
      n_eqs++;
    end
    n_words++;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return MinWord;
      1:       return MaxWord;
      2:       return NegOne;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input logic signed [31:0] base);
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = $urandom_range(1, 30);
      2:       v = $urandom;
      3:       v = pick_extreme();
      default: v = base * $urandom_range(1, 500);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] rand_rhs(input logic signed [31:0] base);
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = 0;
      2:       v = pick_extreme();
      default: v = base * $urandom_range(0, 1000000);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic log_mismatch(input string why, input verdict_t want, input logic [39:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected solvable=%0d gcd=%h, got solvable=%0d gcd=%h pad=%h",
               $realtime, why, want.solvable, want.gcd, got[0], got[32:1], got[39:33]);
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_verdicts.size() == 0) begin
        log_mismatch("unexpected word", '0, m_data);
      end else begin
        want = expected_verdicts.pop_front();
        if (m_data[0] !== want.solvable || m_data[32:1] !== want.gcd || m_data[39:33] !== '0)
          log_mismatch("wrong verdict", want, m_data);
        if (m_data[0] === 1'b1) n_solvable++;
      end
    end
  end

  // output side, with one long hold-off so the block backs up
  initial begin
    int unsigned stall_left;
    logic        hold_done;
    m_ready    = 1'b0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_ready = 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HoldCycles - 1;
        m_ready    = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_ready    = 1'b0;
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  initial begin
    int unsigned        n_random;
    int unsigned        eq_len;
    logic               paused;
    logic signed [31:0] base;
    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    s_user      = 1'b0;
    s_last      = 1'b0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    gcd_acc     = 0;
    any_nonzero = 1'b0;
    mismatches  = 0;
    n_words     = 0;
    n_eqs       = 0;
    n_solvable  = 0;
    n_random    = 0;
    paused      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++)
      send_word(directed_rows[i].coef, directed_rows[i].rhs, directed_rows[i].known,
                directed_rows[i].last, directed_rows[i].typed, directed_rows[i].solv,
                directed_rows[i].gcd);

    while (n_random < RandomWords) begin
      if (!paused && n_random >= 200) begin
        // drain everything before going on
        @(negedge clk_i);
        s_valid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      if (n_random >= 400) hold_req = 1'b1;
      if (n_random >= 700) gaps_on = 1'b0;
      eq_len = $urandom_range(1, 6);
      base = $urandom_range(1, 2000);
      for (int k = 1; k <= eq_len; k++) begin
        if (k == eq_len)
          send_word(rand_coef(base), rand_rhs(base), $urandom_range(0, 9) != 0, 1'b1,
                    1'b0, 1'b0, 32'd0);
        else
          send_word(rand_coef(base), $urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0,
                    32'd0);
        n_random++;
      end
    end
    @(negedge clk_i);
    s_valid = 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("sent %0d words in %0d equations, %0d verdicts found a solution",
             n_words, n_eqs, n_solvable);
    $display("included zero and extreme coefficients, a drained pause and a long output hold");
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
